/* rtl/kti_pkg.sv */
// kti_pkg: types, constants and codes shared by the keyframe table interpolator
// no dependencies
`default_nettype none
package kti_pkg;

  localparam int KEY_SLOTS   = 1024;
  localparam int IDX_W       = $clog2(KEY_SLOTS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int ID_CEILING  = 1000;
  localparam int ID_LIMIT    = (ID_CEILING < KEY_SLOTS) ? ID_CEILING : KEY_SLOTS;

  localparam int KIND_W      = 3;
  localparam int ID_W        = 10;
  localparam int TIME_W      = 16;
  localparam int VALUE_W     = 32;
  localparam int WORD_W      = 1 + TIME_W + VALUE_W;

  localparam int QUEUE_DEPTH = 2;

  localparam int DIFF_W      = VALUE_W + 1;
  localparam int PROD_W      = DIFF_W + TIME_W + 1;
  localparam int DIV_NUM_W   = PROD_W;
  localparam int DIV_DEN_W   = TIME_W + 1;
  localparam int DIV_CNT_W   = $clog2(DIV_NUM_W + 1);
  localparam int SUM_W       = VALUE_W + 3;

  localparam logic [KIND_W-1:0] KIND_ADD       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SET_TIME  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SET_VALUE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EVAL      = 3'd4;
  localparam logic [KIND_W-1:0] KIND_STATUS    = 3'd5;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_REMOVE,
    OP_SET_TIME,
    OP_SET_VALUE,
    OP_EVAL,
    OP_STATUS,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e                       op;
    logic [ID_W-1:0]           key_id;
    logic [TIME_W-1:0]         key_time;
    logic signed [VALUE_W-1:0] key_value;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_MODIFY,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_DONE
  } back_state_e;

endpackage
`default_nettype wire

/* rtl/kti_if.sv */
// request and response channel interfaces of the keyframe table interpolator
// depends on kti_pkg
`default_nettype none
interface kti_req_if;
  logic                                valid;
  logic                                ready;
  logic [kti_pkg::KIND_W-1:0]          kind;
  logic [kti_pkg::ID_W-1:0]            key_id;
  logic [kti_pkg::TIME_W-1:0]          key_time;
  logic signed [kti_pkg::VALUE_W-1:0]  key_value;

  modport source (output valid, kind, key_id, key_time, key_value, input ready);
  modport sink   (input valid, kind, key_id, key_time, key_value, output ready);
endinterface

interface kti_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [kti_pkg::ID_W-1:0]            assigned_id;
  logic signed [kti_pkg::VALUE_W-1:0]  result_value;
  logic                                key_at_time;
  logic                                left_exists;
  logic                                right_exists;

  modport source (output valid, assigned_id, result_value, key_at_time, left_exists,
                  right_exists, input ready);
  modport sink   (input valid, assigned_id, result_value, key_at_time, left_exists,
                  right_exists, output ready);
endinterface
`default_nettype wire

/* rtl/kti_div.sv */
// kti_div: restoring divider, one quotient bit per cycle
// depends on kti_pkg
`default_nettype none
module kti_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [kti_pkg::DIV_NUM_W-1:0]   num_i,
  input  logic [kti_pkg::DIV_DEN_W-1:0]   den_i,
  output logic                            done_o,
  output logic [kti_pkg::DIV_NUM_W-1:0]   quot_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [kti_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [kti_pkg::DIV_NUM_W-1:0]   num_q, num_d;
  logic [kti_pkg::DIV_DEN_W-1:0]   rem_q, rem_d;
  logic [kti_pkg::DIV_DEN_W-1:0]   den_q, den_d;
  logic [kti_pkg::DIV_DEN_W:0]     rem_sh;
  logic                            ge;

  always_comb begin
    rem_sh = {rem_q, num_q[kti_pkg::DIV_NUM_W-1]};
    ge     = rem_sh >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = kti_pkg::DIV_CNT_W'(kti_pkg::DIV_NUM_W);
      num_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      num_d = {num_q[kti_pkg::DIV_NUM_W-2:0], ge};
      rem_d = ge ? kti_pkg::DIV_DEN_W'(rem_sh - {1'b0, den_q})
                 : kti_pkg::DIV_DEN_W'(rem_sh);
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == kti_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule
`default_nettype wire

/* rtl/kti_front.sv */
// kti_front: takes request transactions, decodes the kind and queues commands
// depends on kti_pkg and kti_if
`default_nettype none
module kti_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  kti_req_if.sink        req_i,
  input  logic           clear_busy_i,
  output logic           cmd_valid_o,
  output kti_pkg::cmd_t  cmd_o,
  input  logic           cmd_ready_i
);

  kti_pkg::cmd_t  queue_q [kti_pkg::QUEUE_DEPTH];
  kti_pkg::cmd_t  new_cmd;
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           push, pop;

  always_comb begin
    unique case (req_i.kind)
      kti_pkg::KIND_ADD:       new_cmd.op = kti_pkg::OP_ADD;
      kti_pkg::KIND_REMOVE:    new_cmd.op = kti_pkg::OP_REMOVE;
      kti_pkg::KIND_SET_TIME:  new_cmd.op = kti_pkg::OP_SET_TIME;
      kti_pkg::KIND_SET_VALUE: new_cmd.op = kti_pkg::OP_SET_VALUE;
      kti_pkg::KIND_EVAL:      new_cmd.op = kti_pkg::OP_EVAL;
      kti_pkg::KIND_STATUS:    new_cmd.op = kti_pkg::OP_STATUS;
      default:                 new_cmd.op = kti_pkg::OP_NONE;
    endcase
    new_cmd.key_id    = req_i.key_id;
    new_cmd.key_time  = req_i.key_time;
    new_cmd.key_value = req_i.key_value;
  end

  assign req_i.ready = (count_q != 2'(kti_pkg::QUEUE_DEPTH)) && !clear_busy_i;
  assign push        = req_i.valid && req_i.ready;
  assign cmd_valid_o = count_q != 2'd0;
  assign cmd_o       = queue_q[rd_ptr_q];
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= new_cmd;
    end
  end

endmodule
`default_nettype wire

/* rtl/kti_back.sv */
// kti_back: keyframe table memory, slot scan sequencer, interpolation and result register
// depends on kti_pkg, kti_if and kti_div
`default_nettype none
module kti_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  kti_pkg::cmd_t  cmd_i,
  output logic           cmd_ready_o,
  output logic           clear_busy_o,
  kti_rsp_if.source      rsp_o
);

  localparam int TOP = kti_pkg::WORD_W - 1;

  kti_pkg::back_state_e state_q, state_d;

  logic [kti_pkg::WORD_W-1:0]   mem_q [kti_pkg::KEY_SLOTS];
  logic [kti_pkg::WORD_W-1:0]   rdata_q;
  logic                         mem_we;
  logic [kti_pkg::IDX_W-1:0]    mem_waddr, mem_raddr;
  logic [kti_pkg::WORD_W-1:0]   mem_wdata;

  kti_pkg::cmd_t                cmd_q;
  logic [kti_pkg::CNT_W-1:0]    addr_q, addr_d;
  logic                         rd_vld_q, rd_vld_d;
  logic [kti_pkg::IDX_W-1:0]    rd_idx_q;

  logic                         rd_valid;
  logic [kti_pkg::TIME_W-1:0]   rd_time;
  logic signed [kti_pkg::VALUE_W-1:0] rd_value;

  logic                         hi_ok_q, lo_ok_q, mx_ok_q, free_ok_q;
  logic [kti_pkg::TIME_W-1:0]   hi_t_q, lo_t_q, mx_t_q;
  logic signed [kti_pkg::VALUE_W-1:0] hi_v_q, lo_v_q, mx_v_q;
  logic [kti_pkg::IDX_W-1:0]    free_idx_q;

  logic [kti_pkg::ID_W-1:0]     res_id_q;
  logic signed [kti_pkg::VALUE_W-1:0] res_val_q;
  logic                         res_at_q, res_left_q, res_right_q;

  logic signed [kti_pkg::PROD_W-1:0]  prod_q;
  logic signed [kti_pkg::VALUE_W-1:0] base_q;
  logic [kti_pkg::TIME_W-1:0]         den_q;
  logic                               neg_q;

  logic                               out_valid_q, out_valid_d;
  logic [kti_pkg::ID_W-1:0]           out_id_q;
  logic signed [kti_pkg::VALUE_W-1:0] out_val_q;
  logic                               out_at_q, out_left_q, out_right_q;

  logic                               scan_done, id_ok, load_out, eval_special;
  logic [kti_pkg::TIME_W-1:0]         den_c, dt_c;
  logic signed [kti_pkg::DIFF_W-1:0]  diff_c;
  logic signed [kti_pkg::VALUE_W-1:0] special_val;
  logic [kti_pkg::PROD_W-1:0]         mag_c;
  logic [kti_pkg::DIV_NUM_W-1:0]      div_num;
  logic [kti_pkg::DIV_DEN_W-1:0]      div_den;
  logic                               div_start, div_done;
  logic [kti_pkg::DIV_NUM_W-1:0]      div_quot;
  logic signed [kti_pkg::SUM_W-1:0]   q_signed, sum_c;

  assign rd_valid  = rdata_q[TOP];
  assign rd_time   = rdata_q[TOP-1 -: kti_pkg::TIME_W];
  assign rd_value  = rdata_q[kti_pkg::VALUE_W-1:0];
  assign scan_done = (addr_q == kti_pkg::CNT_W'(kti_pkg::KEY_SLOTS)) && !rd_vld_q;
  assign id_ok     = 32'(cmd_q.key_id) < 32'(kti_pkg::KEY_SLOTS);
  assign load_out  = (state_q == kti_pkg::ST_DONE) && (!out_valid_q || rsp_o.ready);

  // interpolation operands, ramp from zero when no key lies before t
  always_comb begin
    den_c  = lo_ok_q ? hi_t_q - lo_t_q : hi_t_q;
    dt_c   = lo_ok_q ? cmd_q.key_time - lo_t_q : cmd_q.key_time;
    diff_c = lo_ok_q ? kti_pkg::DIFF_W'(hi_v_q) - kti_pkg::DIFF_W'(lo_v_q)
                     : kti_pkg::DIFF_W'(hi_v_q);
    eval_special = !mx_ok_q || !hi_ok_q || (den_c == '0);
    if (!mx_ok_q) begin
      special_val = '0;
    end else if (!hi_ok_q) begin
      special_val = mx_v_q;
    end else begin
      special_val = hi_v_q;
    end
    mag_c    = prod_q[kti_pkg::PROD_W-1] ? kti_pkg::PROD_W'(-prod_q)
                                         : kti_pkg::PROD_W'(prod_q);
    div_num  = {mag_c[kti_pkg::PROD_W-2:0], 1'b0} + kti_pkg::DIV_NUM_W'(den_q);
    div_den  = {den_q, 1'b0};
    q_signed = neg_q ? -$signed({2'b00, div_quot[kti_pkg::VALUE_W:0]})
                     : $signed({2'b00, div_quot[kti_pkg::VALUE_W:0]});
    sum_c    = kti_pkg::SUM_W'(base_q) + q_signed;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kti_pkg::ST_CLEAR: begin
        if (addr_q == kti_pkg::CNT_W'(kti_pkg::KEY_SLOTS - 1)) state_d = kti_pkg::ST_IDLE;
      end
      kti_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op) inside
            kti_pkg::OP_ADD, kti_pkg::OP_EVAL, kti_pkg::OP_STATUS:
              state_d = kti_pkg::ST_SCAN;
            kti_pkg::OP_REMOVE, kti_pkg::OP_SET_TIME, kti_pkg::OP_SET_VALUE:
              state_d = kti_pkg::ST_READ;
            default:
              state_d = kti_pkg::ST_DONE;
          endcase
        end
      end
      kti_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_d = (cmd_q.op == kti_pkg::OP_EVAL) ? kti_pkg::ST_MUL : kti_pkg::ST_DONE;
        end
      end
      kti_pkg::ST_READ: begin
        state_d = (cmd_q.op == kti_pkg::OP_REMOVE) ? kti_pkg::ST_DONE : kti_pkg::ST_MODIFY;
      end
      kti_pkg::ST_MODIFY:    state_d = kti_pkg::ST_DONE;
      kti_pkg::ST_MUL:       state_d = eval_special ? kti_pkg::ST_DONE : kti_pkg::ST_DIV_START;
      kti_pkg::ST_DIV_START: state_d = kti_pkg::ST_DIV_WAIT;
      kti_pkg::ST_DIV_WAIT: begin
        if (div_done) state_d = kti_pkg::ST_DONE;
      end
      kti_pkg::ST_DONE: begin
        if (load_out) state_d = kti_pkg::ST_IDLE;
      end
      default: state_d = kti_pkg::ST_CLEAR;
    endcase
  end

  // outputs and memory control
  always_comb begin
    cmd_ready_o  = state_q == kti_pkg::ST_IDLE;
    clear_busy_o = state_q == kti_pkg::ST_CLEAR;
    div_start    = state_q == kti_pkg::ST_DIV_START;
    mem_we       = 1'b0;
    mem_waddr    = addr_q[kti_pkg::IDX_W-1:0];
    mem_wdata    = '0;
    mem_raddr    = addr_q[kti_pkg::IDX_W-1:0];
    unique case (state_q)
      kti_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
      end
      kti_pkg::ST_SCAN: begin
        if (scan_done && cmd_q.op == kti_pkg::OP_ADD && free_ok_q) begin
          mem_we    = 1'b1;
          mem_waddr = free_idx_q;
          mem_wdata = {1'b1, cmd_q.key_time, cmd_q.key_value};
        end
      end
      kti_pkg::ST_READ: begin
        mem_raddr = kti_pkg::IDX_W'(cmd_q.key_id);
        if (cmd_q.op == kti_pkg::OP_REMOVE && id_ok) begin
          mem_we    = 1'b1;
          mem_waddr = kti_pkg::IDX_W'(cmd_q.key_id);
        end
      end
      kti_pkg::ST_MODIFY: begin
        mem_waddr = kti_pkg::IDX_W'(cmd_q.key_id);
        if (id_ok && rd_valid) begin
          mem_we    = 1'b1;
          mem_wdata = (cmd_q.op == kti_pkg::OP_SET_TIME)
                    ? {1'b1, cmd_q.key_time, rd_value}
                    : {1'b1, rd_time, cmd_q.key_value};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  always_comb begin
    addr_d      = addr_q;
    rd_vld_d    = 1'b0;
    out_valid_d = (out_valid_q && !rsp_o.ready) || load_out;
    if (state_q == kti_pkg::ST_CLEAR) begin
      addr_d = addr_q + 1'b1;
    end else if (state_q == kti_pkg::ST_IDLE && cmd_valid_i) begin
      addr_d = kti_pkg::CNT_W'(1);
    end else if (state_q == kti_pkg::ST_SCAN &&
                 addr_q != kti_pkg::CNT_W'(kti_pkg::KEY_SLOTS)) begin
      addr_d   = addr_q + 1'b1;
      rd_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kti_pkg::ST_CLEAR;
      addr_q      <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= addr_q[kti_pkg::IDX_W-1:0];
    if (state_q == kti_pkg::ST_IDLE && cmd_valid_i) begin
      cmd_q       <= cmd_i;
      hi_ok_q     <= 1'b0;
      lo_ok_q     <= 1'b0;
      mx_ok_q     <= 1'b0;
      free_ok_q   <= 1'b0;
      res_id_q    <= '0;
      res_val_q   <= '0;
      res_at_q    <= 1'b0;
      res_left_q  <= 1'b0;
      res_right_q <= 1'b0;
    end
    if (state_q == kti_pkg::ST_SCAN && rd_vld_q) begin
      if (rd_valid) begin
        if (rd_time >= cmd_q.key_time && (!hi_ok_q || rd_time <= hi_t_q)) begin
          hi_ok_q <= 1'b1;
          hi_t_q  <= rd_time;
          hi_v_q  <= rd_value;
        end
        if (rd_time < cmd_q.key_time && (!lo_ok_q || rd_time > lo_t_q)) begin
          lo_ok_q <= 1'b1;
          lo_t_q  <= rd_time;
          lo_v_q  <= rd_value;
        end
        if (!mx_ok_q || rd_time > mx_t_q) begin
          mx_ok_q <= 1'b1;
          mx_t_q  <= rd_time;
          mx_v_q  <= rd_value;
        end
        if (cmd_q.op == kti_pkg::OP_STATUS) begin
          if (rd_time == cmd_q.key_time) res_at_q <= 1'b1;
          if (rd_time < cmd_q.key_time) res_left_q <= 1'b1;
          if (rd_time > cmd_q.key_time) res_right_q <= 1'b1;
        end
      end else if (!free_ok_q &&
                   {1'b0, rd_idx_q} < kti_pkg::CNT_W'(kti_pkg::ID_LIMIT)) begin
        free_ok_q  <= 1'b1;
        free_idx_q <= rd_idx_q;
      end
    end
    if (state_q == kti_pkg::ST_SCAN && scan_done &&
        cmd_q.op == kti_pkg::OP_ADD && free_ok_q) begin
      res_id_q <= kti_pkg::ID_W'(free_idx_q);
    end
    if (state_q == kti_pkg::ST_MUL) begin
      prod_q <= kti_pkg::PROD_W'(diff_c * $signed({1'b0, dt_c}));
      base_q <= lo_ok_q ? lo_v_q : '0;
      den_q  <= den_c;
      if (eval_special) res_val_q <= special_val;
    end
    if (state_q == kti_pkg::ST_DIV_START) begin
      neg_q <= prod_q[kti_pkg::PROD_W-1];
    end
    if (state_q == kti_pkg::ST_DIV_WAIT && div_done) begin
      res_val_q <= sum_c[kti_pkg::VALUE_W-1:0];
    end
    if (load_out) begin
      out_id_q    <= res_id_q;
      out_val_q   <= res_val_q;
      out_at_q    <= res_at_q;
      out_left_q  <= res_left_q;
      out_right_q <= res_right_q;
    end
  end

  kti_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.assigned_id  = out_id_q;
  assign rsp_o.result_value = out_val_q;
  assign rsp_o.key_at_time  = out_at_q;
  assign rsp_o.left_exists  = out_left_q;
  assign rsp_o.right_exists = out_right_q;

endmodule
`default_nettype wire

/* rtl/keyframe_table_interpolator.sv */
// keyframe_table_interpolator: top level, command front end and table back end
// depends on kti_pkg, kti_if, kti_front and kti_back
//
//   channel  dir  fields
//   req_i    in   kind, key_id, key_time, key_value
//   rsp_o    out  assigned_id, result_value, key_at_time, left_exists,
//                 right_exists
//
// after reset a pass over every slot clears the table; no request is taken meanwhile
// add, evaluate and status walk slots 1 to 1023 through one memory read port;
// evaluate then adds a multiply and a divide
// remove reads and clears the slot, set time and set value read it and write it back
// a two-entry queue takes requests while the back end works; one response
// register lets the next transaction start while a result waits
`default_nettype none
module keyframe_table_interpolator (
  input  logic       clk_i,
  input  logic       rst_ni,
  kti_req_if.sink    req_i,
  kti_rsp_if.source  rsp_o
);

  logic           cmd_valid;
  logic           cmd_ready;
  logic           clear_busy;
  kti_pkg::cmd_t  cmd;

  kti_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .clear_busy_i (clear_busy),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_ready_i  (cmd_ready)
  );

  kti_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_ready_o  (cmd_ready),
    .clear_busy_o (clear_busy),
    .rsp_o        (rsp_o)
  );

endmodule
`default_nettype wire

/* rtl/kti_checker.sv */
// kti_checker: port level checks on the response channel, bound to the top level
// depends on kti_pkg
`default_nettype none
module kti_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              rsp_valid_i,
  input logic                              rsp_ready_i,
  input logic [kti_pkg::ID_W-1:0]          rsp_assigned_id_i,
  input logic [kti_pkg::VALUE_W-1:0]       rsp_result_value_i,
  input logic                              rsp_key_at_time_i,
  input logic                              rsp_left_exists_i,
  input logic                              rsp_right_exists_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped before transaction");

  a_id_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> 32'(rsp_assigned_id_i) < 32'(kti_pkg::ID_CEILING))
    else $error("assigned id beyond ceiling");

  a_add_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_assigned_id_i != '0 |->
      rsp_result_value_i == '0 && !rsp_key_at_time_i && !rsp_left_exists_i &&
      !rsp_right_exists_i)
    else $error("add response carries other fields");

  a_status_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_key_at_time_i || rsp_left_exists_i || rsp_right_exists_i) |->
      rsp_result_value_i == '0 && rsp_assigned_id_i == '0)
    else $error("status response carries other fields");

endmodule

bind keyframe_table_interpolator kti_checker u_kti_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_assigned_id_i  (rsp_o.assigned_id),
  .rsp_result_value_i (rsp_o.result_value),
  .rsp_key_at_time_i  (rsp_o.key_at_time),
  .rsp_left_exists_i  (rsp_o.left_exists),
  .rsp_right_exists_i (rsp_o.right_exists)
);
`default_nettype wire

/* bench/tb_kti_if.sv */
// bench file for the keyframe table interpolator; the request and response channel
// interfaces it uses are the ones that the block declares in rtl/kti_if.sv
`timescale 1ns / 1ps

/* bench/tb_keyframe_table_interpolator.sv */
// testbench for keyframe_table_interpolator: drives keyframe requests through the
// request channel, predicts every response with its own table model and checks them
// depends on kti_pkg, kti_if and the rtl of the block
`timescale 1ns / 1ps
module tb_keyframe_table_interpolator;

  typedef struct {
    logic [kti_pkg::ID_W-1:0]           assigned_id;
    logic signed [kti_pkg::VALUE_W-1:0] result_value;
    logic                               key_at_time;
    logic                               left_exists;
    logic                               right_exists;
  } reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  kti_req_if req_ch ();
  kti_rsp_if rsp_ch ();

  keyframe_table_interpolator uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch.sink),
    .rsp_o  (rsp_ch.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  bit                                 key_live [kti_pkg::KEY_SLOTS];
  logic [kti_pkg::TIME_W-1:0]         key_stamp [kti_pkg::KEY_SLOTS];
  logic signed [kti_pkg::VALUE_W-1:0] key_val [kti_pkg::KEY_SLOTS];
  reply_t                             replies_due [$];
  int                                 failures = 0;
  int                                 idle_cycles = 0;
  int                                 live_count = 0;
  bit                                 drain_done = 1'b0;

  function automatic longint round_quot(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic signed [kti_pkg::VALUE_W-1:0] interp_at(
    logic [kti_pkg::TIME_W-1:0] t);
    int hi;
    int lo;
    int mx;
    longint v0;
    longint v1;
    hi = 0;
    lo = 0;
    mx = 0;
    for (int i = 1; i < kti_pkg::KEY_SLOTS; i++) begin
      if (!key_live[i]) continue;
      if (key_stamp[i] >= t && (hi == 0 || key_stamp[i] <= key_stamp[hi])) hi = i;
      if (key_stamp[i] < t && (lo == 0 || key_stamp[i] > key_stamp[lo])) lo = i;
      if (mx == 0 || key_stamp[i] > key_stamp[mx]) mx = i;
    end
    if (mx == 0) return '0;
    if (hi == 0) return key_val[mx];
    if (lo == 0) begin
      if (key_stamp[hi] == 0) return key_val[hi];
      return kti_pkg::VALUE_W'(round_quot(longint'(key_val[hi]) * longint'(t),
                                          longint'(key_stamp[hi])));
    end
    v0 = key_val[lo];
    v1 = key_val[hi];
    return kti_pkg::VALUE_W'(v0 + round_quot((v1 - v0) * longint'(t - key_stamp[lo]),
                             longint'(key_stamp[hi]) - longint'(key_stamp[lo])));
  endfunction

  function automatic reply_t apply_request(logic [kti_pkg::KIND_W-1:0] kind,
                                           logic [kti_pkg::ID_W-1:0] id,
                                           logic [kti_pkg::TIME_W-1:0] t,
                                           logic signed [kti_pkg::VALUE_W-1:0] v);
    reply_t r;
    r = '{default: '0};
    case (kind)
      kti_pkg::KIND_ADD: begin
        for (int i = 1; i < kti_pkg::ID_LIMIT; i++) begin
          if (!key_live[i]) begin
            key_live[i] = 1'b1;
            key_stamp[i] = t;
            key_val[i] = v;
            r.assigned_id = kti_pkg::ID_W'(i);
            live_count++;
            break;
          end
        end
      end
      kti_pkg::KIND_REMOVE: begin
        if (id < kti_pkg::KEY_SLOTS && key_live[id]) begin
          key_live[id] = 1'b0;
          live_count--;
        end
      end
      kti_pkg::KIND_SET_TIME:
        if (id < kti_pkg::KEY_SLOTS && key_live[id]) key_stamp[id] = t;
      kti_pkg::KIND_SET_VALUE:
        if (id < kti_pkg::KEY_SLOTS && key_live[id]) key_val[id] = v;
      kti_pkg::KIND_EVAL: r.result_value = interp_at(t);
      kti_pkg::KIND_STATUS: begin
        for (int i = 1; i < kti_pkg::KEY_SLOTS; i++) begin
          if (!key_live[i]) continue;
          if (key_stamp[i] == t) r.key_at_time = 1'b1;
          if (key_stamp[i] < t) r.left_exists = 1'b1;
          if (key_stamp[i] > t) r.right_exists = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // called at a falling edge; leaves valid high so a following request can go back to back
  task automatic send_request(logic [kti_pkg::KIND_W-1:0] kind,
                              logic [kti_pkg::ID_W-1:0] id,
                              logic [kti_pkg::TIME_W-1:0] t,
                              logic signed [kti_pkg::VALUE_W-1:0] v);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind <= kind;
    req_ch.key_id <= id;
    req_ch.key_time <= t;
    req_ch.key_value <= v;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    replies_due.insert(replies_due.size(), apply_request(kind, id, t, v));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (replies_due.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [kti_pkg::ID_W-1:0] any_live_id();
    int tries;
    int i;
    tries = 0;
    i = $urandom_range(1, kti_pkg::ID_LIMIT - 1);
    while (!key_live[i] && tries < 2000) begin
      i = (i % (kti_pkg::ID_LIMIT - 1)) + 1;
      tries++;
    end
    return kti_pkg::ID_W'(i);
  endfunction

  task automatic test_directed();
    send_request(kti_pkg::KIND_EVAL, '0, 16'd100, '0);
    send_request(kti_pkg::KIND_STATUS, '0, 16'd0, '0);
    send_request(kti_pkg::KIND_ADD, '0, 16'd0, 32'sh7fff_ffff);
    send_request(kti_pkg::KIND_EVAL, '0, 16'd0, '0);
    send_request(kti_pkg::KIND_EVAL, '0, 16'hffff, '0);
    send_request(kti_pkg::KIND_SET_TIME, 10'd1, 16'd1000, '0);
    send_request(kti_pkg::KIND_EVAL, '0, 16'd333, '0);
    send_request(kti_pkg::KIND_ADD, '0, 16'hffff, 32'sh8000_0000);
    send_request(kti_pkg::KIND_EVAL, '0, 16'd30000, '0);
    send_request(kti_pkg::KIND_EVAL, '0, 16'hffff, '0);
    send_request(kti_pkg::KIND_ADD, '0, 16'd1000, 32'sd12345);
    send_request(kti_pkg::KIND_EVAL, '0, 16'd1000, '0);
    send_request(kti_pkg::KIND_STATUS, '0, 16'd1000, '0);
    send_request(kti_pkg::KIND_STATUS, '0, 16'hffff, '0);
    send_request(kti_pkg::KIND_SET_VALUE, 10'd2, '0, 32'sh0001_0000);
    send_request(kti_pkg::KIND_SET_VALUE, 10'd500, '0, 32'sd5);
    send_request(kti_pkg::KIND_REMOVE, 10'h3ff, '0, '0);
    send_request(kti_pkg::KIND_REMOVE, 10'd1, '0, '0);
    send_request(kti_pkg::KIND_EVAL, '0, 16'd7, '0);
    send_request(kti_pkg::KIND_ADD, '0, 16'd5, -32'sd3);
    send_request(3'd6, 10'h3ff, 16'hffff, -32'sd1);
    send_request(3'd7, 10'h2aa, 16'h5555, 32'sh5555_5555);
    send_request(kti_pkg::KIND_EVAL, '0, 16'd3, '0);
    wait_drained();
  endtask

  task automatic test_random(int count);
    logic [kti_pkg::KIND_W-1:0]         kind;
    logic [kti_pkg::ID_W-1:0]           id;
    logic [kti_pkg::TIME_W-1:0]         t;
    logic signed [kti_pkg::VALUE_W-1:0] v;
    int                                 pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) kind = (live_count > 12) ? kti_pkg::KIND_REMOVE : kti_pkg::KIND_ADD;
      else if (pick < 33) kind = kti_pkg::KIND_REMOVE;
      else if (pick < 43) kind = kti_pkg::KIND_SET_TIME;
      else if (pick < 53) kind = kti_pkg::KIND_SET_VALUE;
      else if (pick < 80) kind = kti_pkg::KIND_EVAL;
      else if (pick < 97) kind = kti_pkg::KIND_STATUS;
      else kind = kti_pkg::KIND_W'($urandom_range(6, 7));
      id = ($urandom_range(0, 4) != 0 && live_count > 0) ? any_live_id()
                                                         : kti_pkg::ID_W'($urandom);
      case ($urandom_range(0, 3))
        0: t = 16'($urandom);
        1: t = 16'($urandom_range(0, 64));
        2: t = (live_count > 0) ? key_stamp[any_live_id()] : 16'hffff;
        default: t = 16'($urandom_range(0, 4000));
      endcase
      case ($urandom_range(0, 2))
        0: v = 32'($urandom);
        1: v = 32'($signed($urandom_range(0, 400000)) - 200000);
        default: v = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      endcase
      send_request(kind, id, t, v);
      if (n == count / 2) wait_drained();
    end
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    reply_t exp_r;
    if (rsp_ch.valid && rsp_ch.ready) begin
      if (replies_due.size() == 0) begin
        $error("response with no request outstanding");
        failures++;
      end else begin
        exp_r = replies_due.pop_front();
        if (rsp_ch.assigned_id !== exp_r.assigned_id) begin
          $error("assigned_id expected %0d actual %0d", exp_r.assigned_id, rsp_ch.assigned_id);
          failures++;
        end
        if (rsp_ch.result_value !== exp_r.result_value) begin
          $error("result_value expected %0d actual %0d", exp_r.result_value,
                 rsp_ch.result_value);
          failures++;
        end
        if (rsp_ch.key_at_time !== exp_r.key_at_time) begin
          $error("key_at_time expected %0b actual %0b", exp_r.key_at_time, rsp_ch.key_at_time);
          failures++;
        end
        if (rsp_ch.left_exists !== exp_r.left_exists) begin
          $error("left_exists expected %0b actual %0b", exp_r.left_exists, rsp_ch.left_exists);
          failures++;
        end
        if (rsp_ch.right_exists !== exp_r.right_exists) begin
          $error("right_exists expected %0b actual %0b", exp_r.right_exists,
                 rsp_ch.right_exists);
          failures++;
        end
      end
    end
  end

  // response side draws a wait before each transaction
  always begin : rsp_sink
    int pause;
    @(negedge clk_i);
    pause = $urandom_range(0, 14);
    if (pause != 0) begin
      rsp_ch.ready <= 1'b0;
      repeat (pause) @(negedge clk_i);
    end
    rsp_ch.ready <= 1'b1;
    @(posedge clk_i);
    while (!rsp_ch.valid) @(posedge clk_i);
  end

  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.kind = '0;
    req_ch.key_id = '0;
    req_ch.key_time = '0;
    req_ch.key_value = '0;
    rsp_ch.ready = 1'b0;
    for (int i = 0; i < kti_pkg::KEY_SLOTS; i++) begin
      key_live[i] = 1'b0;
      key_stamp[i] = '0;
      key_val[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(515);
    wait_drained();
    repeat (1200) @(posedge clk_i);
    drain_done = 1'b1;
    if (failures == 0 && replies_due.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    wait (idle_cycles >= 60000 && !drain_done);
    $display("Regression FAIL");
    $finish;
  end

endmodule
